// ----- sv/stpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpa_pkg
// Shared widths, microcode encodings and the control store of the
// segment tree point-add / range-sum unit.
// ----------------------------------------------------------------------------
package stpa_pkg;

  localparam int POS_W = 11;
  localparam int SUM_W = 64;

  typedef logic [3:0] step_t;

  // datapath action of one control word
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CLEAR,
    ACT_ACCEPT,
    ACT_ADD,
    ACT_DRAIN,
    ACT_QUERY,
    ACT_POST
  } act_t;

  // jump condition; jump to target when true, else fall through
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CLR_MORE,
    C_NO_ITEM,
    C_SKIP,
    C_QUERY,
    C_ADD_MORE,
    C_Q_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uc_word_t;

  localparam step_t ST_CLEAR  = 4'd0;
  localparam step_t ST_IDLE   = 4'd1;
  localparam step_t ST_CHECK  = 4'd2;
  localparam step_t ST_BRANCH = 4'd3;
  localparam step_t ST_ALOOP  = 4'd4;
  localparam step_t ST_ADRAIN = 4'd5;
  localparam step_t ST_QLOOP  = 4'd6;
  localparam step_t ST_QDRAIN = 4'd7;
  localparam step_t ST_WAIT   = 4'd8;
  localparam step_t ST_POST   = 4'd9;

  // control store
  function automatic uc_word_t uc_word(input step_t step);
    uc_word_t w;
    unique case (step)
      ST_CLEAR:  w = '{ACT_CLEAR,  C_CLR_MORE, ST_CLEAR};
      ST_IDLE:   w = '{ACT_ACCEPT, C_NO_ITEM,  ST_IDLE};
      ST_CHECK:  w = '{ACT_NONE,   C_SKIP,     ST_WAIT};
      ST_BRANCH: w = '{ACT_NONE,   C_QUERY,    ST_QLOOP};
      ST_ALOOP:  w = '{ACT_ADD,    C_ADD_MORE, ST_ALOOP};
      ST_ADRAIN: w = '{ACT_DRAIN,  C_ALWAYS,   ST_WAIT};
      ST_QLOOP:  w = '{ACT_QUERY,  C_Q_MORE,   ST_QLOOP};
      ST_QDRAIN: w = '{ACT_NONE,   C_NEVER,    ST_WAIT};
      ST_WAIT:   w = '{ACT_NONE,   C_OUT_BUSY, ST_WAIT};
      ST_POST:   w = '{ACT_POST,   C_ALWAYS,   ST_IDLE};
      default:   w = '{ACT_NONE,   C_ALWAYS,   ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- sv/stpa_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpa channel interfaces
// Valid/ready channels for input items, result items and the
// element count write.
// ----------------------------------------------------------------------------
interface stpa_in_if import stpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [POS_W-1:0] position;
  logic [SUM_W-1:0] delta;
  logic [POS_W-1:0] range_low;
  logic [POS_W-1:0] range_high;

  modport source(output valid, kind, position, delta, range_low, range_high,
                 input ready);
  modport sink(input valid, kind, position, delta, range_low, range_high,
               output ready);
endinterface

interface stpa_out_if import stpa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] range_sum;
  logic                    bad_position;

  modport source(output valid, range_sum, bad_position, input ready);
  modport sink(input valid, range_sum, bad_position, output ready);
endinterface

interface stpa_cfg_if import stpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] element_count;

  modport source(output valid, element_count, input ready);
  modport sink(input valid, element_count, output ready);
endinterface

// ----- sv/stpa_node_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpa_node_ram
// Node sum store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module stpa_node_ram import stpa_pkg::*; #(
  parameter int DEPTH = 2048
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [SUM_W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr_a,
  output logic [SUM_W-1:0]             rdata_a,
  input  logic [$clog2(DEPTH)-1:0]     raddr_b,
  output logic [SUM_W-1:0]             rdata_b
);

  logic [SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- sv/segment_tree_point_add_range_sum_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_point_add_range_sum_unit
// Binary segment tree of 64-bit wrapping sums over positions 1..element_count,
// with point add and inclusive range sum, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      word
//  -------  ---  -------------  ------------------------------------------
//  in_ch    in   valid/ready    kind, position, delta, range_low, range_high
//  out_ch   out  valid/ready    range_sum, bad_position (one per in word)
//  cfg_ch   in   valid/ready    element_count (always ready, saturates)
//
//  Work: an add does one read-modify-write per tree level on the node store,
//  L = log2(2*MAX_ELEMENTS) tree levels (11 at the default). A query makes k
//  loop passes (up to L), two node reads per pass. A flagged or empty item
//  skips the tree walk and only posts its result.
//  Reset: rst_n is synchronous; afterwards a clearing pass zeroes the store,
//  one node a cycle over all 2*MAX_ELEMENTS nodes, with in_ch held not ready.
//  Stalls: one output register; the next word is taken while a result waits,
//  and a finished item waits for that register to empty before posting.
// ----------------------------------------------------------------------------
module segment_tree_point_add_range_sum_unit import stpa_pkg::*; #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  stpa_in_if.sink    in_ch,
  stpa_out_if.source out_ch,
  stpa_cfg_if.sink   cfg_ch
);

  localparam int DEPTH = 2 * MAX_ELEMENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = AW + 1;            // tree index incl. exclusive end 2*M
  localparam int EC_RST_I = (MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024;
  localparam logic [POS_W-1:0] EC_RST   = POS_W'(EC_RST_I);
  localparam logic [POS_W-1:0] EC_MAX   = POS_W'(MAX_ELEMENTS);
  localparam logic [AW-1:0]    CLR_LAST = AW'(DEPTH - 1);
  localparam logic [IW-1:0]    LEAF_BASE = IW'(MAX_ELEMENTS);

  // sequencer
  step_t    step_r, step_nxt;
  uc_word_t uc;
  logic     cond_hit;

  // control registers
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [POS_W-1:0] ec_r, ec_nxt;
  logic             wv_r, wv_nxt;            // node write pending
  logic             va_r, va_nxt;            // port A read feeds the sum
  logic             vb_r, vb_nxt;            // port B read feeds the sum
  logic             out_valid_r, out_valid_nxt;

  // payload registers
  logic             kind_r, kind_nxt;
  logic             skip_r, skip_nxt;
  logic             bad_r, bad_nxt;
  logic [SUM_W-1:0] delta_r, delta_nxt;
  logic [IW-1:0]    l_r, l_nxt;              // add: node index, query: left end
  logic [IW-1:0]    r_r, r_nxt;              // query: exclusive right end
  logic [AW-1:0]    wa_r, wa_nxt;
  logic [SUM_W-1:0] pair_r, pair_nxt;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic             out_bad_r, out_bad_nxt;

  // node store
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [SUM_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr_b;
  logic [SUM_W-1:0] rda, rdb;

  logic in_acc, cfg_acc;

  // query pass arithmetic
  logic [IW-1:0] l_inc, r_dec, q_l_n, q_r_n;

  // accept-time checks
  logic pos_ok, lo_ok, hi_ok;

  assign uc      = uc_word(step_r);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready         = (uc.act == ACT_ACCEPT);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.range_sum    = out_sum_r;
  assign out_ch.bad_position = out_bad_r;

  assign pos_ok = (in_ch.position   != '0) && (in_ch.position   <= ec_r);
  assign lo_ok  = (in_ch.range_low  != '0) && (in_ch.range_low  <= ec_r);
  assign hi_ok  = (in_ch.range_high != '0) && (in_ch.range_high <= ec_r);

  // one bottom-up query pass: take odd left node, take node left of odd right end
  assign l_inc       = l_r + IW'(l_r[0]);
  assign r_dec       = r_r - IW'(r_r[0]);
  assign q_l_n       = l_inc >> 1;
  assign q_r_n       = r_dec >> 1;
  assign mem_raddr_b = r_dec[AW-1:0];

  // next step
  always_comb begin
    unique case (uc.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_CLR_MORE: cond_hit = (clr_r != CLR_LAST);
      C_NO_ITEM:  cond_hit = !in_acc;
      C_SKIP:     cond_hit = skip_r;
      C_QUERY:    cond_hit = kind_r;
      C_ADD_MORE: cond_hit = ((l_r >> 1) != '0);
      C_Q_MORE:   cond_hit = (q_l_n < q_r_n);
      C_OUT_BUSY: cond_hit = out_valid_r && !out_ch.ready;
      default:    cond_hit = 1'b1;
    endcase
    step_nxt = cond_hit ? uc.target : step_t'(step_r + 4'd1);
  end

  // datapath controls from the action field
  always_comb begin
    clr_nxt       = clr_r;
    ec_nxt        = ec_r;
    wv_nxt        = wv_r;
    va_nxt        = 1'b0;
    vb_nxt        = 1'b0;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    skip_nxt      = skip_r;
    bad_nxt       = bad_r;
    delta_nxt     = delta_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    wa_nxt        = wa_r;
    out_sum_nxt   = out_sum_r;
    out_bad_nxt   = out_bad_r;
    pair_nxt      = (va_r ? rda : '0) + (vb_r ? rdb : '0);
    acc_nxt       = acc_r + pair_r;
    mem_we        = 1'b0;
    mem_waddr     = wa_r;
    mem_wdata     = rda + delta_r;

    if (cfg_acc) begin
      ec_nxt = (32'(cfg_ch.element_count) > 32'(MAX_ELEMENTS)) ? EC_MAX
                                                              : cfg_ch.element_count;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (uc.act)
      ACT_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      ACT_ACCEPT: begin
        if (in_acc) begin
          kind_nxt  = in_ch.kind;
          delta_nxt = in_ch.delta;
          acc_nxt   = '0;
          wv_nxt    = 1'b0;
          if (!in_ch.kind) begin
            bad_nxt  = !pos_ok;
            skip_nxt = !pos_ok;
            l_nxt    = LEAF_BASE + IW'(in_ch.position) - IW'(1);
          end else begin
            bad_nxt  = !(lo_ok && hi_ok);
            skip_nxt = !(lo_ok && hi_ok) || (in_ch.range_low > in_ch.range_high);
            l_nxt    = LEAF_BASE + IW'(in_ch.range_low) - IW'(1);
          end
          r_nxt = LEAF_BASE + IW'(in_ch.range_high);
        end
      end
      ACT_ADD: begin
        // write back the level read last cycle, read the next one up
        mem_we = wv_r;
        wa_nxt = l_r[AW-1:0];
        wv_nxt = 1'b1;
        l_nxt  = l_r >> 1;
      end
      ACT_DRAIN: begin
        mem_we = wv_r;
        wv_nxt = 1'b0;
      end
      ACT_QUERY: begin
        va_nxt = l_r[0];
        vb_nxt = r_r[0];
        l_nxt  = q_l_n;
        r_nxt  = q_r_n;
      end
      ACT_POST: begin
        out_valid_nxt = 1'b1;
        out_sum_nxt   = acc_r;
        out_bad_nxt   = bad_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_CLEAR;
      clr_r       <= '0;
      ec_r        <= EC_RST;
      wv_r        <= 1'b0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      clr_r       <= clr_nxt;
      ec_r        <= ec_nxt;
      wv_r        <= wv_nxt;
      va_r        <= va_nxt;
      vb_r        <= vb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    skip_r    <= skip_nxt;
    bad_r     <= bad_nxt;
    delta_r   <= delta_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    wa_r      <= wa_nxt;
    pair_r    <= pair_nxt;
    acc_r     <= acc_nxt;
    out_sum_r <= out_sum_nxt;
    out_bad_r <= out_bad_nxt;
  end

  stpa_node_ram #(
    .DEPTH(DEPTH)
  ) u_node_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (l_r[AW-1:0]),
    .rdata_a (rda),
    .raddr_b (mem_raddr_b),
    .rdata_b (rdb)
  );

endmodule
